// ===== sv/ppd_pkg.sv =====
package ppd_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIAGE,
    ST_LOOKUP,
    ST_COMPARE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic first;
    logic write_sym;
    logic read;
    logic follow;
    logic extend;
    logic div_start;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic first;
    logic mismatch;
    logic candidate;
    logic div_done;
    logic divisible;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/ppd_in_if.sv =====
interface ppd_in_if;
  logic                     valid;
  logic                     ready;
  logic [ppd_pkg::SYM_W-1:0] symbol;
  logic                     start_new;

  modport source (output valid, output symbol, output start_new, input ready);
  modport sink   (input valid, input symbol, input start_new, output ready);
endinterface

// ===== sv/ppd_out_if.sv =====
interface ppd_out_if;
  logic                     valid;
  logic                     ready;
  logic [ppd_pkg::OUT_W-1:0] prefix_length;
  logic [ppd_pkg::OUT_W-1:0] repeat_count;

  modport source (output valid, output prefix_length, output repeat_count, input ready);
  modport sink   (input valid, input prefix_length, input repeat_count, output ready);
endinterface

// ===== sv/periodic_prefix_detector.sv =====
// Periodic prefix detector.
// The input channel carries one symbol per item together with a start flag
// that begins a new string. For each symbol the block extends the prefix
// function of the string and, when the prefix seen so far is a shorter block
// repeated at least twice, sends one item on the result channel with the
// prefix length and the repeat count. Symbols past MAX_LEN in one string are
// dropped and give no result.
// One symbol is processed at a time: the controller takes it (IDLE), triages
// it (TRIAGE) and compares it with the border symbol (COMPARE), following one
// failure link per LOOKUP and COMPARE pair in the symbol and border memories
// (one read port each), then checks for a candidate (CHECK); the first symbol
// of a string and a dropped symbol end after TRIAGE. When the border is at
// least half the length, the bit-serial divider that tests the period and
// forms the count runs (DIVIDE) and the result is then loaded (EMIT).
// The result sits in an output register; the next symbol is accepted while it
// waits, and a further result stalls only until the receiver takes it.
// Reset clears the position and border, so the first symbol after reset
// starts a new string; the memories need no clearing.
module periodic_prefix_detector #(
  parameter int MAX_LEN = ppd_pkg::MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ppd_in_if.sink    in_chan,
  ppd_out_if.source out_chan
);

  ppd_pkg::cmd_t    cmd;
  ppd_pkg::status_t st;

  ppd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ppd_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_symbol         (in_chan.symbol),
    .in_start_new      (in_chan.start_new),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_prefix_length (out_chan.prefix_length),
    .out_repeat_count  (out_chan.repeat_count)
  );

endmodule

// ===== sv/ppd_div.sv =====
module ppd_div #(
  parameter int LW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [LW-1:0] num,
  input  logic [LW-1:0] den,
  output logic          done,
  output logic [LW-1:0] quo,
  output logic [LW-1:0] rem
);

  localparam int CW = $clog2(LW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] quo_r, quo_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] den_r, den_nxt;
  logic [LW:0]   shifted;
  logic [LW:0]   diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted  = {rem_r, quo_r[LW-1]};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(LW);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[LW]) begin
        rem_nxt = diff[LW-1:0];
        quo_nxt = {quo_r[LW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[LW-1:0];
        quo_nxt = {quo_r[LW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/ppd_ctrl.sv =====
module ppd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppd_pkg::status_t st,
  output ppd_pkg::cmd_t    cmd
);

  ppd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ppd_pkg::ST_TRIAGE;
      end
      ppd_pkg::ST_TRIAGE: begin
        priority if (st.full) state_nxt = ppd_pkg::ST_IDLE;
        else if (st.first)    state_nxt = ppd_pkg::ST_IDLE;
        else                  state_nxt = ppd_pkg::ST_COMPARE;
      end
      ppd_pkg::ST_LOOKUP: state_nxt = ppd_pkg::ST_COMPARE;
      ppd_pkg::ST_COMPARE: begin
        if (st.mismatch) state_nxt = ppd_pkg::ST_LOOKUP;
        else             state_nxt = ppd_pkg::ST_CHECK;
      end
      ppd_pkg::ST_CHECK: begin
        if (st.candidate) state_nxt = ppd_pkg::ST_DIVIDE;
        else              state_nxt = ppd_pkg::ST_IDLE;
      end
      ppd_pkg::ST_DIVIDE: begin
        if (st.div_done) begin
          if (st.divisible) state_nxt = ppd_pkg::ST_EMIT;
          else              state_nxt = ppd_pkg::ST_IDLE;
        end
      end
      ppd_pkg::ST_EMIT: begin
        if (!st.out_busy) state_nxt = ppd_pkg::ST_IDLE;
      end
      default: state_nxt = ppd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ppd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ppd_pkg::ST_TRIAGE: begin
        if (!st.full) begin
          if (st.first) begin
            cmd.first = 1'b1;
          end else begin
            cmd.write_sym = 1'b1;
            cmd.read      = 1'b1;
          end
        end
      end
      ppd_pkg::ST_LOOKUP:  cmd.read = 1'b1;
      ppd_pkg::ST_COMPARE: begin
        if (st.mismatch) cmd.follow = 1'b1;
        else             cmd.extend = 1'b1;
      end
      ppd_pkg::ST_CHECK:  cmd.div_start = st.candidate;
      ppd_pkg::ST_DIVIDE: ;
      ppd_pkg::ST_EMIT:   cmd.emit = !st.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== sv/ppd_dp.sv =====
module ppd_dp #(
  parameter int MAX_LEN = ppd_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ppd_pkg::cmd_t              cmd,
  output ppd_pkg::status_t           st,
  input  logic [ppd_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_start_new,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ppd_pkg::OUT_W-1:0]  out_prefix_length,
  output logic [ppd_pkg::OUT_W-1:0]  out_repeat_count
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic [ppd_pkg::SYM_W-1:0] sym_mem [MAX_LEN];
  logic [AW-1:0]             bord_mem [MAX_LEN];

  logic [LW-1:0]             pos_r;
  logic [LW-1:0]             k_r;
  logic [ppd_pkg::SYM_W-1:0] sym_r;
  logic [ppd_pkg::SYM_W-1:0] sym_q;
  logic [AW-1:0]             bord_q;
  logic                      out_valid_r;
  logic [ppd_pkg::OUT_W-1:0] out_len_r;
  logic [ppd_pkg::OUT_W-1:0] out_cnt_r;

  logic [LW-1:0] k_prev;
  logic [LW-1:0] bord_ext;
  logic [LW-1:0] k_ext;
  logic [LW-1:0] period;
  logic          div_done;
  logic [LW-1:0] quo;
  logic [LW-1:0] rem;

  assign k_prev   = k_r - LW'(1);
  assign bord_ext = LW'(bord_q);
  assign k_ext    = k_r + LW'(sym_q == sym_r);
  assign period   = pos_r - k_r;

  // Symbol and border stores: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.first || cmd.write_sym) begin
      sym_mem[pos_r[AW-1:0]] <= sym_r;
    end
    if (cmd.first) begin
      bord_mem[pos_r[AW-1:0]] <= '0;
    end else if (cmd.extend) begin
      bord_mem[pos_r[AW-1:0]] <= k_ext[AW-1:0];
    end
    if (cmd.read) begin
      sym_q  <= sym_mem[k_r[AW-1:0]];
      bord_q <= bord_mem[k_prev[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take && in_start_new) begin
        pos_r <= '0;
        k_r   <= '0;
      end else if (cmd.first) begin
        pos_r <= LW'(1);
        k_r   <= '0;
      end else if (cmd.follow) begin
        // Step down the failure link; a link that does not shrink ends the walk.
        k_r <= (bord_ext < k_r) ? bord_ext : '0;
      end else if (cmd.extend) begin
        k_r   <= k_ext;
        pos_r <= pos_r + LW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sym_r <= in_symbol;
    end
    if (cmd.emit) begin
      out_len_r <= ppd_pkg::OUT_W'(pos_r);
      out_cnt_r <= ppd_pkg::OUT_W'(quo);
    end
  end

  ppd_div #(
    .LW (LW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (pos_r),
    .den   (period),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  always_comb begin
    st.full      = (pos_r >= LW'(MAX_LEN));
    st.first     = (pos_r == '0);
    st.mismatch  = (k_r != '0) && (sym_q != sym_r);
    st.candidate = ({k_r, 1'b0} >= {1'b0, pos_r});
    st.div_done  = div_done;
    st.divisible = (rem == '0);
    st.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_prefix_length = out_len_r;
  assign out_repeat_count  = out_cnt_r;

endmodule
